FILE: hdl/rlsd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package rlsd_pkg;

    localparam int WORD_W = 16;
    localparam int DIM_W = 10;
    localparam int COL_W = 12;
    localparam int INDEX_W = 20;
    localparam int COLOR_W = 24;
    localparam int FAULT_W = 2;
    localparam int SUM_W = WORD_W + 1;
    localparam int TDATA_W = 48;
    localparam int TUSER_W = 4;

    localparam int MAX_DIM = 1024;
    localparam int PAIR_LIMIT = 2048;
    localparam logic [COL_W-1:0] COL_CAP = '1;
    localparam logic [DIM_W-1:0] DIM_RESET = 10'd44;

    localparam logic [FAULT_W-1:0] FAULT_NONE = 2'd0;
    localparam logic [FAULT_W-1:0] FAULT_PAIR = 2'd1;
    localparam logic [FAULT_W-1:0] FAULT_WIDTH = 2'd2;

    localparam logic CFG_WIDTH = 1'b0;
    localparam logic CFG_HEIGHT = 1'b1;

    typedef struct packed {
        logic [DIM_W-1:0] width;
        logic [DIM_W-1:0] height;
    } cfg_t;

    typedef struct packed {
        logic [WORD_W-1:0] word;
        logic              start;
    } in_word_t;

    typedef struct packed {
        logic [INDEX_W-1:0] index;
        logic [COLOR_W-1:0] color;
        logic               is_pixel;
        logic               row_end;
        logic               done;
        logic [FAULT_W-1:0] fault;
    } result_t;

    // floor(c * 255 / 31) written as 8c plus floor(7c / 31).
    function automatic logic [7:0] expand5(input logic [4:0] c);
        logic [2:0] frac;
        frac = 3'(c >= 5'd5) + 3'(c >= 5'd9) + 3'(c >= 5'd14) + 3'(c >= 5'd18)
             + 3'(c >= 5'd23) + 3'(c >= 5'd27) + 3'(c >= 5'd31);
        return {c, 3'b000} + {5'b00000, frac};
    endfunction

    function automatic logic [COLOR_W-1:0] rgb555_to_24(input logic [WORD_W-1:0] w);
        return {expand5(w[4:0]), expand5(w[9:5]), expand5(w[14:10])};
    endfunction

endpackage

`default_nettype wire

FILE: hdl/rlsd_cfg.sv
`timescale 1ns / 1ps
`default_nettype none

module rlsd_cfg
    import rlsd_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             cfg_valid,
    output logic                  cfg_ready,
    input  wire logic             cfg_index,
    input  wire logic [DIM_W-1:0] cfg_data,
    output cfg_t                  cfg
);

    cfg_t cfg_reg;

    assign cfg_ready = 1'b1;
    assign cfg = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.width  <= DIM_RESET;
            cfg_reg.height <= DIM_RESET;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_WIDTH:  cfg_reg.width  <= cfg_data;
                CFG_HEIGHT: cfg_reg.height <= cfg_data;
                default:    cfg_reg.width  <= cfg_reg.width;
            endcase
        end
    end

endmodule

`default_nettype wire

FILE: hdl/rlsd_in_stage.sv
`timescale 1ns / 1ps
`default_nettype none

module rlsd_in_stage
    import rlsd_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     s_valid,
    output logic          s_ready,
    input  wire in_word_t s_word,
    output logic          held_valid,
    output in_word_t      held_word,
    input  wire logic     take
);

    logic     valid_reg;
    in_word_t word_reg;

    assign s_ready    = !valid_reg || take;
    assign held_valid = valid_reg;
    assign held_word  = word_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (s_valid && s_ready)
        begin
            valid_reg <= 1'b1;
        end
        else if (take)
        begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_valid && s_ready)
        begin
            word_reg <= s_word;
        end
    end

endmodule

`default_nettype wire

FILE: hdl/rlsd_core.sv
`timescale 1ns / 1ps
`default_nettype none

module rlsd_core
    import rlsd_pkg::*;
#(
    parameter int PAIR_LIMIT_P = PAIR_LIMIT
)
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire cfg_t     cfg,
    input  wire logic     held_valid,
    input  wire in_word_t held_word,
    output logic          take,
    output logic          out_valid,
    output result_t       out_result,
    input  wire logic     out_ready
);

    localparam int SKIP_W = $clog2(PAIR_LIMIT_P + 1);
    localparam int LEFT_W = $clog2(PAIR_LIMIT_P);
    localparam int CADD_W = ((SKIP_W > COL_W) ? SKIP_W : COL_W) + 1;
    localparam logic [WORD_W-1:0] LIMIT_WORD = WORD_W'(PAIR_LIMIT_P);
    localparam logic [SUM_W-1:0] LIMIT_SUM = SUM_W'(PAIR_LIMIT_P);

    typedef enum logic [1:0] {
        PH_SKIP = 2'd0,
        PH_RUN  = 2'd1,
        PH_PIX  = 2'd2
    } phase_t;

    phase_t              phase_reg, phase_next;
    logic [COL_W-1:0]    column_reg, column_next;
    logic [DIM_W-1:0]    row_reg, row_next;
    logic [INDEX_W-1:0]  row_base_reg, row_base_next;
    logic [SKIP_W-1:0]   skip_reg, skip_next;
    logic [LEFT_W-1:0]   left_reg, left_next;
    logic                halted_reg, halted_next;
    logic                out_valid_reg;
    result_t             out_result_reg;

    phase_t              phase_cur;
    logic [COL_W-1:0]    column_cur;
    logic [DIM_W-1:0]    row_cur;
    logic [INDEX_W-1:0]  row_base_cur;
    logic [SKIP_W-1:0]   skip_cur;
    logic [LEFT_W-1:0]   left_cur;
    logic                halted_cur;

    logic                dims_ok;
    logic [WORD_W-1:0]   w;
    logic [SUM_W-1:0]    pair_sum;
    logic [CADD_W-1:0]   col_add;
    logic [DIM_W-1:0]    row_inc;
    logic                emit;
    result_t             res;

    assign take       = held_valid && (!out_valid_reg || out_ready);
    assign out_valid  = out_valid_reg;
    assign out_result = out_result_reg;
    assign w          = held_word.word;

    assign dims_ok = (cfg.width != '0) && ({22'd0, cfg.width} < 32'(MAX_DIM))
                  && (cfg.height != '0) && ({22'd0, cfg.height} < 32'(MAX_DIM));

    always_comb
    begin
        if (held_word.start)
        begin
            phase_cur    = PH_SKIP;
            column_cur   = '0;
            row_cur      = '0;
            row_base_cur = '0;
            skip_cur     = '0;
            left_cur     = '0;
            halted_cur   = 1'b0;
        end
        else
        begin
            phase_cur    = phase_reg;
            column_cur   = column_reg;
            row_cur      = row_reg;
            row_base_cur = row_base_reg;
            skip_cur     = skip_reg;
            left_cur     = left_reg;
            halted_cur   = halted_reg;
        end

        pair_sum = {1'b0, w} + SUM_W'(skip_cur);
        col_add  = CADD_W'(column_cur) + CADD_W'(skip_cur);
        row_inc  = row_cur + 1'b1;

        phase_next    = phase_cur;
        column_next   = column_cur;
        row_next      = row_cur;
        row_base_next = row_base_cur;
        skip_next     = skip_cur;
        left_next     = left_cur;
        halted_next   = halted_cur;
        emit          = 1'b0;
        res           = '0;

        if (!halted_cur)
        begin
            unique case (phase_cur)
                PH_SKIP:
                begin
                    skip_next  = (w > LIMIT_WORD) ? SKIP_W'(PAIR_LIMIT_P) : SKIP_W'(w);
                    phase_next = PH_RUN;
                end
                PH_RUN:
                begin
                    if (pair_sum >= LIMIT_SUM)
                    begin
                        halted_next = 1'b1;
                        emit        = 1'b1;
                        res.fault   = FAULT_PAIR;
                    end
                    else if (pair_sum == '0)
                    begin
                        column_next   = '0;
                        row_next      = row_inc;
                        row_base_next = row_base_cur + INDEX_W'(cfg.width);
                        phase_next    = PH_SKIP;
                        emit          = 1'b1;
                        res.row_end   = 1'b1;
                        if (row_inc >= cfg.height)
                        begin
                            halted_next = 1'b1;
                            res.done    = 1'b1;
                        end
                    end
                    else
                    begin
                        column_next = (col_add > CADD_W'(COL_CAP)) ? COL_CAP
                                                                   : col_add[COL_W-1:0];
                        left_next   = w[LEFT_W-1:0];
                        phase_next  = (w != '0) ? PH_PIX : PH_SKIP;
                    end
                end
                PH_PIX:
                begin
                    column_next = (column_cur < COL_CAP) ? column_cur + 1'b1 : COL_CAP;
                    left_next   = (left_cur != '0) ? left_cur - 1'b1 : left_cur;
                    if (left_next == '0)
                    begin
                        phase_next = PH_SKIP;
                    end
                    emit = 1'b1;
                    if (column_cur >= {2'b00, cfg.width})
                    begin
                        res.fault = FAULT_WIDTH;
                    end
                    else
                    begin
                        res.index    = row_base_cur + INDEX_W'(column_cur);
                        res.color    = rgb555_to_24(w);
                        res.is_pixel = 1'b1;
                    end
                end
                default:
                begin
                    phase_next = PH_SKIP;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_SKIP;
            column_reg    <= '0;
            row_reg       <= '0;
            row_base_reg  <= '0;
            skip_reg      <= '0;
            left_reg      <= '0;
            halted_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (take && dims_ok)
            begin
                phase_reg     <= phase_next;
                column_reg    <= column_next;
                row_reg       <= row_next;
                row_base_reg  <= row_base_next;
                skip_reg      <= skip_next;
                left_reg      <= left_next;
                halted_reg    <= halted_next;
                out_valid_reg <= emit;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take && dims_ok && emit)
        begin
            out_result_reg <= res;
        end
    end

endmodule

`default_nettype wire

FILE: hdl/run_length_sprite_decoder.sv
`timescale 1ns / 1ps
`default_nettype none

// Run-length sprite decoder for RGB555 sprites. One 16-bit stream word is taken per cycle
// on the s_ side while the output side keeps up; skip and run words give no result, while
// each pixel word, each end of row and each fault gives one word on the m_ side, with the
// colour expanded to 24 bits (red in the low byte). A word passes through an input
// register, one pass of decode logic and a result register, so the sustained rate is one
// word per cycle for as long as the output side keeps up. Set tuser on the first word of a
// sprite to restart decoding. Width and height are written through the cfg_ port; the user
// must write them only while the block is idle; the block itself does not enforce this. While
// either is zero, words are dropped without effect.
module run_length_sprite_decoder
    import rlsd_pkg::*;
#(
    parameter int PAIR_LIMIT_P = PAIR_LIMIT
)
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               s_tvalid,
    output logic                    s_tready,
    input  wire logic [WORD_W-1:0]  s_tdata,   // stream_word
    input  wire logic               s_tuser,   // tile_start
    output logic                    m_tvalid,
    input  wire logic               m_tready,
    output logic [TDATA_W-1:0]      m_tdata,   // pixel_index, pixel_color, zero fill
    output logic [TUSER_W-1:0]      m_tuser,   // is_pixel, row_end, fault
    output logic                    m_tlast,   // sprite_done
    input  wire logic               cfg_valid,
    output logic                    cfg_ready,
    input  wire logic               cfg_index,
    input  wire logic [DIM_W-1:0]   cfg_data
);

    cfg_t     cfg;
    in_word_t s_word;
    in_word_t held_word;
    logic     held_valid;
    logic     take;
    result_t  out_result;

    assign s_word.word  = s_tdata;
    assign s_word.start = s_tuser;

    rlsd_cfg u_cfg
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    rlsd_in_stage u_in
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_valid    (s_tvalid),
        .s_ready    (s_tready),
        .s_word     (s_word),
        .held_valid (held_valid),
        .held_word  (held_word),
        .take       (take)
    );

    rlsd_core #(
        .PAIR_LIMIT_P (PAIR_LIMIT_P)
    ) u_core
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg),
        .held_valid (held_valid),
        .held_word  (held_word),
        .take       (take),
        .out_valid  (m_tvalid),
        .out_result (out_result),
        .out_ready  (m_tready)
    );

    assign m_tdata = {4'b0000, out_result.color, out_result.index};
    assign m_tuser = {out_result.fault, out_result.row_end, out_result.is_pixel};
    assign m_tlast = out_result.done;

endmodule

`default_nettype wire

FILE: hdl/rlsd_checker.sv
`timescale 1ns / 1ps
`default_nettype none

module rlsd_checker
    import rlsd_pkg::*;
(
    input wire logic               clk,
    input wire logic               rst_n,
    input wire logic               m_tvalid,
    input wire logic               m_tready,
    input wire logic [TDATA_W-1:0] m_tdata,
    input wire logic [TUSER_W-1:0] m_tuser,
    input wire logic               m_tlast
);

    // A stalled output word keeps its contents.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
                                 && $stable(m_tlast))
        else $error("output word changed while stalled");

    // A pixel word carries neither a row end nor a fault.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser[0] |-> !m_tuser[1] && (m_tuser[3:2] == FAULT_NONE) && !m_tlast)
        else $error("pixel word with row end or fault");

    // The end of a sprite is always reported on a row end.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tlast |-> m_tuser[1] && (m_tuser[3:2] == FAULT_NONE))
        else $error("sprite end without row end");

    // Words other than pixels have zero index and colour.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tuser[0] |-> (m_tdata == '0))
        else $error("non-pixel word with payload");

    // Every output word reports exactly one kind of event.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> $onehot({m_tuser[0], m_tuser[1], m_tuser[3:2] == FAULT_PAIR,
                              m_tuser[3:2] == FAULT_WIDTH}))
        else $error("output word of no single kind");

endmodule

bind run_length_sprite_decoder rlsd_checker u_rlsd_checker
(
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);

`default_nettype wire

FILE: test/tb_run_length_sprite_decoder.sv
`timescale 1ns / 1ps

module tb_run_length_sprite_decoder;
    import rlsd_pkg::*;

    localparam int PHASES = 12;
    localparam int PHASE_WORDS = 32;
    localparam int SETTLE_CYCLES = 12;
    localparam int STALL_CYCLES = 300;
    localparam int RUN_LIMIT_NS = 400000;

    typedef enum logic [1:0] {
        WAIT_SKIP,
        WAIT_RUN,
        IN_PIXELS
    } decode_phase_e;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [WORD_W-1:0]    s_tdata = '0;
    logic                 s_tuser = 1'b0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [TDATA_W-1:0]   m_tdata;
    logic [TUSER_W-1:0]   m_tuser;
    logic                 m_tlast;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic                 cfg_index = 1'b0;
    logic [DIM_W-1:0]     cfg_data = '0;

    in_word_t  stream_words [$];
    result_t   predicted_results [$];
    int        words_queued = 0;
    int        words_taken = 0;
    int        mismatches = 0;
    int        send_idle = 0;
    int        recv_idle = 0;
    int        stall_left = 0;
    bit        stall_req = 1'b0;
    bit        in_taken = 1'b0;
    bit        start_next = 1'b0;

    int phase_width [PHASES] = '{1, 1023, 0, 9, 16, 7, 30, 1023, 5, 12, 3, 20};
    int phase_height [PHASES] = '{1, 1023, 6, 0, 3, 2, 4, 1, 1023, 1, 5, 2};

    // Shadow copy of the decoder state and its registers.
    logic [DIM_W-1:0]   exp_width;
    logic [DIM_W-1:0]   exp_height;
    decode_phase_e      exp_phase;
    logic [COL_W-1:0]   exp_column;
    logic [DIM_W-1:0]   exp_row;
    logic [INDEX_W-1:0] exp_row_base;
    logic [11:0]        exp_skip;
    logic [10:0]        exp_left;
    logic               exp_halted;

    run_length_sprite_decoder DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        forever #1 clk = ~clk;
    end

    initial
    begin
        #(RUN_LIMIT_NS);
        $display("Regression FAIL");
        $finish;
    end

    task automatic report(input string msg);
        if (mismatches < 50)
        begin
            $display("%0t: %s", $realtime, msg);
        end
        mismatches++;
    endtask

    function automatic logic [7:0] widen_channel(input logic [4:0] c);
        return 8'((int'(c) * 255) / 31);
    endfunction

    function automatic void clear_decoder();
        exp_phase = WAIT_SKIP;
        exp_column = '0;
        exp_row = '0;
        exp_row_base = '0;
        exp_skip = '0;
        exp_left = '0;
        exp_halted = 1'b0;
    endfunction

    function automatic bit decode_word(input logic [WORD_W-1:0] w, input logic start,
                                       output result_t r);
        int unsigned sum;
        int unsigned col_sum;
        logic [COL_W-1:0] c;
        r = '0;
        if (exp_width == 0 || exp_height == 0)
        begin
            return 1'b0;
        end
        if (start)
        begin
            clear_decoder();
        end
        if (exp_halted)
        begin
            return 1'b0;
        end
        case (exp_phase)
            WAIT_SKIP:
            begin
                exp_skip = (w > PAIR_LIMIT) ? 12'(PAIR_LIMIT) : w[11:0];
                exp_phase = WAIT_RUN;
                return 1'b0;
            end
            WAIT_RUN:
            begin
                sum = exp_skip + w;
                if (sum >= PAIR_LIMIT)
                begin
                    exp_halted = 1'b1;
                    r.fault = FAULT_PAIR;
                    return 1'b1;
                end
                if (sum == 0)
                begin
                    exp_column = '0;
                    exp_row = exp_row + 1'b1;
                    exp_row_base = exp_row_base + exp_width;
                    exp_phase = WAIT_SKIP;
                    r.row_end = 1'b1;
                    if (exp_row >= exp_height)
                    begin
                        exp_halted = 1'b1;
                        r.done = 1'b1;
                    end
                    return 1'b1;
                end
                col_sum = exp_column + exp_skip;
                exp_column = (col_sum > COL_CAP) ? COL_CAP : col_sum[COL_W-1:0];
                exp_left = w[10:0];
                exp_phase = (w != 0) ? IN_PIXELS : WAIT_SKIP;
                return 1'b0;
            end
            default:
            begin
                c = exp_column;
                if (exp_column < COL_CAP)
                begin
                    exp_column = exp_column + 1'b1;
                end
                if (exp_left > 0)
                begin
                    exp_left = exp_left - 1'b1;
                end
                if (exp_left == 0)
                begin
                    exp_phase = WAIT_SKIP;
                end
                if (c >= exp_width)
                begin
                    r.fault = FAULT_WIDTH;
                    return 1'b1;
                end
                r.index = exp_row_base + c;
                r.color = {widen_channel(w[4:0]), widen_channel(w[9:5]),
                           widen_channel(w[14:10])};
                r.is_pixel = 1'b1;
                return 1'b1;
            end
        endcase
    endfunction

    // Input side: keeps a word on offer until it is taken, then fetches the next.
    always @(negedge clk)
    begin : word_driver
        in_word_t nxt;
        logic     offer;
        if (rst_n)
        begin
            offer = s_tvalid && !in_taken;
            in_taken = 1'b0;
            nxt = '{word: s_tdata, start: s_tuser};
            if (!offer && stream_words.size() != 0 && $urandom_range(99) >= send_idle)
            begin
                nxt = stream_words.pop_front();
                offer = 1'b1;
            end
            s_tvalid <= offer;
            s_tdata <= nxt.word;
            s_tuser <= nxt.start;
        end
    end

    always @(negedge clk)
    begin : result_sink
        if (rst_n)
        begin
            if (stall_req)
            begin
                stall_req = 1'b0;
                stall_left = STALL_CYCLES;
            end
            if (stall_left > 0)
            begin
                stall_left--;
                m_tready <= 1'b0;
            end
            else
            begin
                m_tready <= ($urandom_range(99) >= recv_idle);
            end
        end
    end

    always @(posedge clk)
    begin : monitor
        result_t got;
        result_t want;
        if (rst_n)
        begin
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == CFG_WIDTH)
                begin
                    exp_width = cfg_data;
                end
                else
                begin
                    exp_height = cfg_data;
                end
            end
            if (s_tvalid && s_tready)
            begin
                in_taken = 1'b1;
                words_taken++;
                if (decode_word(s_tdata, s_tuser, want))
                begin
                    predicted_results.push_back(want);
                end
            end
            if (m_tvalid && m_tready)
            begin
                got = '{index: m_tdata[INDEX_W-1:0], color: m_tdata[INDEX_W +: COLOR_W],
                        is_pixel: m_tuser[0], row_end: m_tuser[1], done: m_tlast,
                        fault: m_tuser[3:2]};
                if (predicted_results.size() == 0)
                begin
                    report($sformatf("unexpected result word %h", got));
                end
                else
                begin
                    want = predicted_results.pop_front();
                    if (got.index !== want.index)
                        report($sformatf("pixel_index %h, expected %h", got.index, want.index));
                    if (got.color !== want.color)
                        report($sformatf("pixel_color %h, expected %h", got.color, want.color));
                    if (got.is_pixel !== want.is_pixel)
                        report($sformatf("is_pixel %b, expected %b", got.is_pixel, want.is_pixel));
                    if (got.row_end !== want.row_end)
                        report($sformatf("row_end %b, expected %b", got.row_end, want.row_end));
                    if (got.done !== want.done)
                        report($sformatf("sprite_done %b, expected %b", got.done, want.done));
                    if (got.fault !== want.fault)
                        report($sformatf("fault %0d, expected %0d", got.fault, want.fault));
                end
            end
        end
    end

    task automatic push_word(input int w);
        stream_words.push_back('{word: WORD_W'(w), start: start_next});
        start_next = 1'b0;
        words_queued++;
    endtask

    task automatic write_reg(input logic idx, input int value);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= DIM_W'(value);
        do
            @(posedge clk);
        while (!(cfg_valid && cfg_ready));
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic settle();
        while (words_taken != words_queued || predicted_results.size() != 0)
        begin
            @(negedge clk);
        end
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic gen_sprite(input int w, input int h);
        int rows;
        int segs;
        int pick;
        int skip;
        int run;
        start_next = 1'b1;
        rows = (h >= 1 && h <= 6 && $urandom_range(1) == 0) ? h + $urandom_range(0, 1)
                                                             : $urandom_range(1, 3);
        for (int r = 0; r < rows; r++)
        begin
            segs = $urandom_range(0, 3);
            for (int s = 0; s < segs; s++)
            begin
                pick = $urandom_range(99);
                if (pick < 4)
                begin
                    if ($urandom_range(1))
                    begin
                        push_word($urandom_range(2048, 65535));
                        push_word($urandom_range(0, 65535));
                    end
                    else
                    begin
                        push_word($urandom_range(0, 40));
                        push_word($urandom_range(2048, 65535));
                    end
                    return;
                end
                else if (pick < 7)
                begin
                    start_next = 1'b1;
                end
                else if (pick < 10)
                begin
                    push_word($urandom_range(0, 65535));
                end
                skip = ($urandom_range(9) == 0) ? w + $urandom_range(0, 3)
                                                : $urandom_range(0, w / 3 + 1);
                run = $urandom_range(0, 4);
                push_word(skip);
                push_word(run);
                for (int k = 0; k < run; k++)
                begin
                    push_word($urandom_range(0, 65535));
                end
            end
            push_word(0);
            push_word(0);
        end
    endtask

    initial
    begin : stimulus
        int first_word;
        exp_width = DIM_RESET;
        exp_height = DIM_RESET;
        clear_decoder();
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        send_idle = 26;
        recv_idle = 81;

        // Directed words on the reset geometry of 44 by 44.
        start_next = 1'b1;
        push_word(0);
        push_word(1);
        push_word(16'h0000);
        push_word(42);
        push_word(2);
        push_word(16'h7FFF);
        push_word(16'hFFFF);
        push_word(0);
        push_word(0);
        // Runs of zero length only move the column, here until it saturates.
        push_word(2000);
        push_word(0);
        push_word(2047);
        push_word(0);
        push_word(2047);
        push_word(0);
        push_word(0);
        push_word(1);
        push_word(16'h8000);
        push_word(0);
        push_word(0);
        // A clamped skip that reaches the pair limit, then a word while halted.
        push_word(16'hFFFF);
        push_word(0);
        push_word(16'h1234);
        start_next = 1'b1;
        push_word(5);
        push_word(16'h8000);
        settle();

        for (int i = 0; i < PHASES; i++)
        begin
            if (i == 4)
            begin
                send_idle = 81;
                recv_idle = 26;
            end
            if (i == 8)
            begin
                send_idle = 0;
                recv_idle = 0;
            end
            write_reg(CFG_WIDTH, phase_width[i]);
            write_reg(CFG_HEIGHT, phase_height[i]);
            if (i == 8)
            begin
                stall_req = 1'b1;
            end
            first_word = words_queued;
            while (words_queued - first_word < PHASE_WORDS)
            begin
                gen_sprite(phase_width[i], phase_height[i]);
            end
            settle();
        end

        if (mismatches == 0)
        begin
            $display("Regression PASS");
        end
        else
        begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
